@@ src/dcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcpc_pkg
// Types and constants shared by the daisy-chain PEC checker.
// ----------------------------------------------------------------------------
package dcpc_pkg;

  localparam int MaxDevices    = 16;
  localparam int MaxGroupBytes = 32;

  localparam int GroupLimit  = (MaxGroupBytes > 63) ? 63 : MaxGroupBytes;
  localparam int DeviceLimit = (MaxDevices > 16) ? 16 : MaxDevices;

  localparam logic [7:0] CrcInit = 8'h41;
  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic [5:0] BytesPerDeviceRst = 6'd6;
  localparam logic [4:0] DeviceCountRst    = 5'd1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTES_PER_DEVICE = 1'b0,
    CFG_DEVICE_COUNT     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0] bytes_per_device;
    logic [4:0] device_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_is_pec;
    logic [3:0]  device_index;
    logic        pec_match;
    logic [7:0]  expected_pec;
    logic [15:0] mismatch_flags;
    logic        frame_done;
  } result_t;

endpackage

@@ src/dcpc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dcpc_cfg_regs
// Configuration registers: group length and number of chained devices.
// ----------------------------------------------------------------------------
module dcpc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [dcpc_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [dcpc_pkg::CfgDataW-1:0]  wr_data_i,
  output dcpc_pkg::cfg_t                 cfg_o
);
  import dcpc_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_BYTES_PER_DEVICE: cfg_d.bytes_per_device = wr_data_i[5:0];
        CFG_DEVICE_COUNT:     cfg_d.device_count     = wr_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_device <= BytesPerDeviceRst;
      cfg_q.device_count     <= DeviceCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dcpc_crc8.sv @@
// ----------------------------------------------------------------------------
// dcpc_crc8
// One-byte CRC-8 update, polynomial 0x07, MSB first.
// ----------------------------------------------------------------------------
module dcpc_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);
  import dcpc_pkg::*;

  always_comb begin
    logic [7:0] c;
    c = crc_i ^ byte_i;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

@@ src/dcpc_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// dcpc_frame_tracker
// Frame state (CRC, byte and device positions, mismatch mask) and the result
// for the byte held in the input register.
// ----------------------------------------------------------------------------
module dcpc_frame_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              commit_i,
  input  dcpc_pkg::item_t   item_i,
  input  dcpc_pkg::cfg_t    cfg_i,
  output dcpc_pkg::result_t result_o
);
  import dcpc_pkg::*;

  logic [7:0]  crc_d, crc_q;
  logic [5:0]  bpos_d, bpos_q;
  logic [3:0]  dpos_d, dpos_q;
  logic [15:0] mask_d, mask_q;

  logic [7:0]  crc_cur, crc_upd;
  logic [5:0]  bpos_cur, glen;
  logic [3:0]  dpos_cur;
  logic [4:0]  dlim;
  logic [15:0] mask_cur;
  logic        is_pec, done, match;

  dcpc_crc8 u_crc8 (
    .crc_i  (crc_cur),
    .byte_i (item_i.rx_byte),
    .crc_o  (crc_upd)
  );

  always_comb begin
    crc_cur  = item_i.frame_start ? CrcInit : crc_q;
    bpos_cur = item_i.frame_start ? 6'd0 : bpos_q;
    dpos_cur = item_i.frame_start ? 4'd0 : dpos_q;
    mask_cur = (item_i.frame_start || (bpos_cur == 6'd0 && dpos_cur == 4'd0)) ?
               16'd0 : mask_q;

    if (cfg_i.bytes_per_device == 6'd0) begin
      glen = 6'd1;
    end else if (cfg_i.bytes_per_device > 6'(GroupLimit)) begin
      glen = 6'(GroupLimit);
    end else begin
      glen = cfg_i.bytes_per_device;
    end

    if (cfg_i.device_count == 5'd0) begin
      dlim = 5'd1;
    end else if (cfg_i.device_count > 5'(DeviceLimit)) begin
      dlim = 5'(DeviceLimit);
    end else begin
      dlim = cfg_i.device_count;
    end

    is_pec = bpos_cur >= glen;
    match  = item_i.rx_byte == crc_cur;
    done   = is_pec && (({1'b0, dpos_cur} + 5'd1) >= dlim);

    if (is_pec) begin
      crc_d  = CrcInit;
      bpos_d = 6'd0;
      dpos_d = done ? 4'd0 : dpos_cur + 4'd1;
      mask_d = match ? mask_cur : (mask_cur | (16'd1 << dpos_cur));
    end else begin
      crc_d  = crc_upd;
      bpos_d = bpos_cur + 6'd1;
      dpos_d = dpos_cur;
      mask_d = mask_cur;
    end

    result_o.data_byte      = item_i.rx_byte;
    result_o.byte_is_pec    = is_pec;
    result_o.device_index   = dpos_cur;
    result_o.pec_match      = is_pec && match;
    result_o.expected_pec   = is_pec ? crc_cur : crc_upd;
    result_o.mismatch_flags = mask_d;
    result_o.frame_done     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      bpos_q <= 6'd0;
      dpos_q <= 4'd0;
      mask_q <= 16'd0;
    end else if (commit_i) begin
      crc_q  <= crc_d;
      bpos_q <= bpos_d;
      dpos_q <= dpos_d;
      mask_q <= mask_d;
    end
  end

endmodule

@@ src/daisy_chain_pec_checker.sv @@
// ----------------------------------------------------------------------------
// daisy_chain_pec_checker
// PEC check of a daisy-chained response frame, one byte per transaction.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o     in_item_i (rx_byte, frame_start)
//   out      output     out_valid_o/out_stall_i   out_data_o (result_t)
//   cfg      input      cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// Input register, then result register; one byte per cycle sustained while
// out_stall_i is low, with the CRC-8 update combinational between the two.
// Reset clears both stage valids and the frame state; config takes its
// reset values. A stalled output holds its result; the input register keeps
// accepting until both stages are full, then in_stall_o follows out_stall_i.
// ----------------------------------------------------------------------------
module daisy_chain_pec_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dcpc_pkg::item_t                in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dcpc_pkg::result_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dcpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dcpc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dcpc_pkg::*;

  logic    s1_valid_d, s1_valid_q;
  logic    s2_valid_d, s2_valid_q;
  item_t   s1_item_q;
  result_t s2_res_q;
  result_t res;
  cfg_t    cfg;
  logic    in_acc, s2_load;

  assign cfg_ready_o = 1'b1;

  dcpc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  dcpc_frame_tracker u_frame_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (s2_load),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
    if (s2_load) begin
      s2_res_q <= res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_res_q;

`ifndef SYNTH
  a_done_on_pec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.byte_is_pec)
    else $error("frame_done on a data byte");

  a_match_only_pec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_is_pec |-> !out_data_o.pec_match)
    else $error("pec_match set on a data byte");

  a_match_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_is_pec |->
      out_data_o.pec_match == (out_data_o.data_byte == out_data_o.expected_pec))
    else $error("pec_match disagrees with compared CRC");

  a_mismatch_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_is_pec && !out_data_o.pec_match |->
      out_data_o.mismatch_flags[out_data_o.device_index])
    else $error("mismatch not recorded in mask");
`endif

endmodule

@@ tb/daisy_chain_pec_checker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// daisy_chain_pec_checker_test
// Self-checking bench for the daisy-chain PEC checker. Byte streams (directed
// frames, then random well-formed, truncated and noisy frames) are pushed
// through the block under several group length and device count settings
// with bursty input and patterned output stalls. A scoreboard tracks the
// CRC-8, positions and mismatch mask per byte and compares each result.
// ----------------------------------------------------------------------------
module daisy_chain_pec_checker_test;
  import dcpc_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 60;
  localparam int PhaseItems = 75;

  class pec_frame_scoreboard;
    logic [5:0]  bytes_per_dev;
    logic [4:0]  dev_count;
    logic [7:0]  crc;
    logic [5:0]  byte_pos;
    logic [3:0]  dev_pos;
    logic [15:0] mask;
    result_t     pending_results[$];
    int          errors;

    function new();
      bytes_per_dev = BytesPerDeviceRst;
      dev_count     = DeviceCountRst;
      crc           = CrcInit;
      byte_pos      = '0;
      dev_pos       = '0;
      mask          = '0;
      errors        = 0;
    endfunction

    static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int i = 0; i < 8; i++) begin
        r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
      end
      return r;
    endfunction

    static function int group_len(logic [5:0] v);
      if (v == 0) return 1;
      return (int'(v) > GroupLimit) ? GroupLimit : int'(v);
    endfunction

    static function int device_lim(logic [4:0] v);
      if (v == 0) return 1;
      return (int'(v) > DeviceLimit) ? DeviceLimit : int'(v);
    endfunction

    static function string fmt(result_t r);
      return $sformatf("byte=%h pec=%b dev=%0d match=%b crc=%h flags=%h done=%b",
                       r.data_byte, r.byte_is_pec, r.device_index, r.pec_match,
                       r.expected_pec, r.mismatch_flags, r.frame_done);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [5:0] value);
      case (idx)
        CFG_BYTES_PER_DEVICE: bytes_per_dev = value;
        CFG_DEVICE_COUNT:     dev_count     = value[4:0];
        default: ;
      endcase
    endfunction

    function void note_byte(item_t it);
      result_t r;
      r = '0;
      if (it.frame_start) begin
        crc      = CrcInit;
        byte_pos = '0;
        dev_pos  = '0;
        mask     = '0;
      end
      if (byte_pos == 0 && dev_pos == 0) mask = '0;
      r.data_byte    = it.rx_byte;
      r.device_index = dev_pos;
      if (int'(byte_pos) >= group_len(bytes_per_dev)) begin
        r.byte_is_pec  = 1'b1;
        r.expected_pec = crc;
        r.pec_match    = (it.rx_byte == crc);
        if (!r.pec_match) mask = mask | (16'h1 << dev_pos);
        r.frame_done   = (int'(dev_pos) + 1 >= device_lim(dev_count));
        crc            = CrcInit;
        byte_pos       = '0;
        dev_pos        = r.frame_done ? 4'd0 : dev_pos + 4'd1;
      end else begin
        crc            = crc8_next(crc, it.rx_byte);
        r.expected_pec = crc;
        byte_pos       = byte_pos + 6'd1;
      end
      r.mismatch_flags = mask;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", fmt(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.data_byte !== want.data_byte || got.byte_is_pec !== want.byte_is_pec ||
          got.device_index !== want.device_index || got.pec_match !== want.pec_match ||
          got.expected_pec !== want.expected_pec ||
          got.mismatch_flags !== want.mismatch_flags ||
          got.frame_done !== want.frame_done) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  item_t               in_item     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  result_t             out_data;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  pec_frame_scoreboard sb;
  item_t               stim_q[$];
  bit                  steady      = 1'b0;
  bit                  hold_req    = 1'b0;

  daisy_chain_pec_checker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- stimulus building ----
  task automatic add_frame(bit start, int fill, int bad_pct);
    int         glen;
    int         dlim;
    logic [7:0] c;
    item_t      it;
    glen = pec_frame_scoreboard::group_len(sb.bytes_per_dev);
    dlim = pec_frame_scoreboard::device_lim(sb.dev_count);
    for (int d = 0; d < dlim; d++) begin
      c = CrcInit;
      for (int b = 0; b < glen; b++) begin
        case (fill)
          1:       it.rx_byte = 8'h00;
          2:       it.rx_byte = 8'hFF;
          3:       it.rx_byte = b[0] ? 8'hFF : 8'h00;
          default: it.rx_byte = 8'($urandom);
        endcase
        it.frame_start = start && d == 0 && b == 0;
        c = pec_frame_scoreboard::crc8_next(c, it.rx_byte);
        stim_q.push_back(it);
      end
      it.rx_byte     = c;
      it.frame_start = 1'b0;
      if (int'($urandom_range(0, 99)) < bad_pct)
        it.rx_byte = c ^ 8'($urandom_range(1, 255));
      stim_q.push_back(it);
    end
  endtask

  task automatic add_random(int count);
    int    r;
    int    cut;
    item_t it;
    while (stim_q.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it.rx_byte     = 8'($urandom);
        it.frame_start = 1'($urandom_range(0, 1));
        stim_q.push_back(it);
      end else if (r < 18) begin
        add_frame(1'b1, 0, 15);
        cut = $urandom_range(1, pec_frame_scoreboard::group_len(sb.bytes_per_dev));
        while (cut > 0 && stim_q.size() > 1) begin
          void'(stim_q.pop_back());
          cut--;
        end
      end else begin
        add_frame($urandom_range(0, 4) != 0, 0, 15);
      end
    end
  endtask

  // ---- driving ----
  task automatic drain_stimulus();
    item_t it;
    int    burst;
    burst = $urandom_range(1, 20);
    while (stim_q.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if (!steady && $urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      it = stim_q.pop_front();
      in_valid <= 1'b1;
      in_item  <= it;
      do @(negedge clk); while (in_stall);
      @(posedge clk);
      sb.note_byte(it);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_config(logic [5:0] bpd, logic [5:0] dc);
    write_reg(CFG_BYTES_PER_DEVICE, bpd);
    write_reg(CFG_DEVICE_COUNT, dc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---- receiver stall pattern ----
  initial begin : stall_gen
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (mode_left % 4 < 2);
        endcase
      end
    end
  end

  // ---- result monitor ----
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < IdleLimit) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---- main sequence ----
  initial begin : main_seq
    logic [5:0] bpd_set[7];
    logic [5:0] dc_set[7];
    item_t      it;
    bpd_set = '{6'd1, 6'd0, 6'd3, 6'd63, 6'd2, 6'd4, 6'd6};
    dc_set  = '{6'd4, 6'd0, 6'd16, 6'd1, 6'h3F, 6'h23, 6'd2};
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, six data bytes and one PEC per frame
    add_frame(1'b1, 3, 0);
    add_frame(1'b0, 2, 100);
    it.frame_start = 1'b0;
    it.rx_byte     = 8'h00;
    repeat (3) stim_q.push_back(it);
    add_frame(1'b1, 1, 0);
    it.rx_byte     = 8'hFF;
    it.frame_start = 1'b1;
    stim_q.push_back(it);
    it.rx_byte     = 8'h00;
    stim_q.push_back(it);
    drain_stimulus();

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      set_config(bpd_set[p], dc_set[p]);
      if (p == 0) begin
        // long output hold-off with back-to-back input
        steady   = 1'b1;
        hold_req = 1'b1;
        add_random(30);
        drain_stimulus();
        @(posedge clk);
        steady   = 1'b0;
        add_random(PhaseItems - 30);
        drain_stimulus();
      end else if (p == 1) begin
        add_random(PhaseItems / 2);
        drain_stimulus();
        wait_idle();
        add_random(PhaseItems / 2);
        drain_stimulus();
      end else begin
        add_random(PhaseItems);
        drain_stimulus();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
